FILE: rtl/core/mips_regfile_alu_execute_core_assert.svh
// Assertion helpers used by the checker file.
`ifndef MIPS_REGFILE_ALU_EXECUTE_CORE_ASSERT_SVH
`define MIPS_REGFILE_ALU_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRAE_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRAE_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mrae_pkg.sv
package mrae_pkg;

	localparam int unsigned NREGS      = 32;
	localparam int unsigned IDX_W      = 5;
	localparam int unsigned XLEN       = 32;
	localparam logic [4:0]  SP_INDEX   = 5'd29;
	localparam logic [4:0]  LINK_INDEX = 5'd31;
	localparam logic [31:0] SP_RESET   = 32'h0000_0400;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADDU  = 5'd1,
		OP_SUB   = 5'd2,
		OP_AND   = 5'd3,
		OP_OR    = 5'd4,
		OP_XOR   = 5'd5,
		OP_NOR   = 5'd6,
		OP_NAND  = 5'd7,
		OP_SLT   = 5'd8,
		OP_SLL   = 5'd9,
		OP_SRL   = 5'd10,
		OP_SRA   = 5'd11,
		OP_JR    = 5'd12,
		OP_ADDI  = 5'd13,
		OP_ADDIU = 5'd14,
		OP_LUI   = 5'd15,
		OP_ANDI  = 5'd16,
		OP_ORI   = 5'd17,
		OP_NORI  = 5'd18,
		OP_SLTI  = 5'd19,
		OP_BEQ   = 5'd20,
		OP_BNE   = 5'd21,
		OP_BGTZ  = 5'd22,
		OP_JAL   = 5'd23
	} op_t;

	// Decoded instruction held in the input stage.
	typedef struct packed {
		logic [4:0]        opcode;
		logic [4:0]        tgt_index;
		logic [4:0]        dst_index;
		logic [4:0]        shift_amount;
		logic signed [15:0] imm_value;
		logic [25:0]       jump_target;
		logic [31:0]       current_pc;
	} instr_t;

	// Outcome of one instruction.
	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        write_zero_error;
		logic        overflow_error;
	} result_t;

	// Register file write port.
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] val;
	} wb_t;

	function automatic logic [31:0] reset_value(input logic [4:0] idx);
		return (idx == SP_INDEX) ? SP_RESET : '0;
	endfunction

endpackage

FILE: rtl/core/mrae_regfile.sv
// Register bank: one write port, two registered read ports with bypass
// of the write landing on the same edge. Entries never written read as
// their reset value through per-entry valid bits.
module mrae_regfile (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [4:0]           rd_a_idx,
	input  logic [4:0]           rd_b_idx,
	input  mrae_pkg::wb_t        wb,
	output logic [31:0]          rd_a_data,
	output logic [31:0]          rd_b_data
);

	logic [31:0]                mem [mrae_pkg::NREGS];
	logic [mrae_pkg::NREGS-1:0] vld_q;

	logic [31:0] a_mem_s1, b_mem_s1;
	logic [31:0] a_alt_s1, b_alt_s1;
	logic        a_use_mem_s1, b_use_mem_s1;
	logic        a_fwd, b_fwd;

	assign a_fwd = wb.en && (wb.idx == rd_a_idx);
	assign b_fwd = wb.en && (wb.idx == rd_b_idx);

	always_ff @(posedge clk) begin
		if (wb.en) begin
			mem[wb.idx] <= wb.val;
		end
		if (rd_en) begin
			a_mem_s1     <= mem[rd_a_idx];
			b_mem_s1     <= mem[rd_b_idx];
			a_use_mem_s1 <= !a_fwd && vld_q[rd_a_idx];
			b_use_mem_s1 <= !b_fwd && vld_q[rd_b_idx];
			a_alt_s1     <= a_fwd ? wb.val : mrae_pkg::reset_value(rd_a_idx);
			b_alt_s1     <= b_fwd ? wb.val : mrae_pkg::reset_value(rd_b_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wb.en) begin
			vld_q[wb.idx] <= 1'b1;
		end
	end

	assign rd_a_data = a_use_mem_s1 ? a_mem_s1 : a_alt_s1;
	assign rd_b_data = b_use_mem_s1 ? b_mem_s1 : b_alt_s1;

endmodule

FILE: rtl/core/mrae_alu.sv
// Execute one decoded instruction on its two operands.
module mrae_alu (
	input  mrae_pkg::instr_t  instr,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output mrae_pkg::result_t res
);

	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] op2;
	logic        cin;
	logic [31:0] sum;
	logic        sum_ovf;
	logic [31:0] pc_inc;
	logic [31:0] br_tgt;
	logic        is_sub;
	logic        use_imm;
	logic        wr;
	logic [4:0]  dest;
	logic [31:0] val;
	logic        ovf;
	logic [31:0] nxt;
	mrae_pkg::op_t op;

	assign op      = mrae_pkg::op_t'(instr.opcode);
	assign simm    = {{16{instr.imm_value[15]}}, instr.imm_value};
	assign zimm    = {16'd0, instr.imm_value};
	assign is_sub  = (op == mrae_pkg::OP_SUB);
	assign use_imm = (op == mrae_pkg::OP_ADDI) || (op == mrae_pkg::OP_ADDIU);
	// Share one adder for add, sub and add-immediate.
	assign op2     = is_sub ? ~b : (use_imm ? simm : b);
	assign cin     = is_sub;
	assign sum     = a + op2 + {31'd0, cin};
	assign sum_ovf = (a[31] == op2[31]) && (sum[31] != a[31]);
	assign pc_inc  = instr.current_pc + 32'd1;
	assign br_tgt  = pc_inc + simm;

	always_comb begin
		wr   = 1'b0;
		dest = instr.dst_index;
		val  = '0;
		ovf  = 1'b0;
		nxt  = pc_inc;
		case (op)
			mrae_pkg::OP_ADD: begin
				wr = 1'b1; val = sum; ovf = sum_ovf;
			end
			mrae_pkg::OP_ADDU: begin
				wr = 1'b1; val = sum;
			end
			mrae_pkg::OP_SUB: begin
				wr = 1'b1; val = sum; ovf = sum_ovf;
			end
			mrae_pkg::OP_AND:  begin wr = 1'b1; val = a & b; end
			mrae_pkg::OP_OR:   begin wr = 1'b1; val = a | b; end
			mrae_pkg::OP_XOR:  begin wr = 1'b1; val = a ^ b; end
			mrae_pkg::OP_NOR:  begin wr = 1'b1; val = ~(a | b); end
			mrae_pkg::OP_NAND: begin wr = 1'b1; val = ~(a & b); end
			mrae_pkg::OP_SLT: begin
				wr = 1'b1; val = {31'd0, $signed(a) < $signed(b)};
			end
			mrae_pkg::OP_SLL: begin
				// all-zero sll is the canonical nop
				if (!((instr.dst_index == '0) && (instr.tgt_index == '0) &&
					(instr.shift_amount == '0))) begin
					wr = 1'b1; val = b << instr.shift_amount;
				end
			end
			mrae_pkg::OP_SRL: begin wr = 1'b1; val = b >> instr.shift_amount; end
			mrae_pkg::OP_SRA: begin
				wr = 1'b1; val = $unsigned($signed(b) >>> instr.shift_amount);
			end
			mrae_pkg::OP_JR: nxt = {2'd0, a[31:2]};
			mrae_pkg::OP_ADDI: begin
				wr = 1'b1; dest = instr.tgt_index; val = sum; ovf = sum_ovf;
			end
			mrae_pkg::OP_ADDIU: begin
				wr = 1'b1; dest = instr.tgt_index; val = sum;
			end
			mrae_pkg::OP_LUI: begin
				wr = 1'b1; dest = instr.tgt_index; val = {instr.imm_value, 16'd0};
			end
			mrae_pkg::OP_ANDI: begin wr = 1'b1; dest = instr.tgt_index; val = a & zimm; end
			mrae_pkg::OP_ORI:  begin wr = 1'b1; dest = instr.tgt_index; val = a | zimm; end
			mrae_pkg::OP_NORI: begin
				wr = 1'b1; dest = instr.tgt_index; val = ~(a | zimm);
			end
			mrae_pkg::OP_SLTI: begin
				wr = 1'b1; dest = instr.tgt_index; val = {31'd0, $signed(a) < $signed(simm)};
			end
			mrae_pkg::OP_BEQ: begin
				if (a == b) nxt = br_tgt;
			end
			mrae_pkg::OP_BNE: begin
				if (a != b) nxt = br_tgt;
			end
			mrae_pkg::OP_BGTZ: begin
				if (!a[31] && (a != '0)) nxt = br_tgt;
			end
			mrae_pkg::OP_JAL: begin
				wr = 1'b1; dest = mrae_pkg::LINK_INDEX; val = {pc_inc[29:0], 2'b00};
				nxt = {6'd0, instr.jump_target};
			end
			default: ;
		endcase

		res.next_pc          = nxt;
		res.overflow_error   = ovf;
		res.write_zero_error = wr && (dest == '0);
		res.reg_written      = wr && (dest != '0);
		res.written_index    = res.reg_written ? dest : '0;
		res.written_value    = res.reg_written ? val : '0;
	end

endmodule

FILE: rtl/core/mips_regfile_alu_execute_core.sv
// Channel | Handshake             | Payload
// req     | req_valid / req_ready | opcode, src_index, tgt_index, dst_index,
//         |                       | shift_amount, imm_value, jump_target, current_pc
// rsp     | rsp_valid / rsp_ready | next_pc, reg_written, written_index, written_value,
//         |                       | write_zero_error, overflow_error
//
// One instruction per clock sustained while responses are accepted.
// The register bank read is captured into the input stage, then the result register holds the ALU result.
// Write-back lands as the input stage moves into the result register; a read on the
// same edge takes the bypassed value, so dependent instructions issue back to back.
// Reset clears the valid flags; register 29 reads 0x400 and all others zero until written.
// A stalled response holds the input stage, which then stops taking requests.
module mips_regfile_alu_execute_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [4:0]         opcode,
	input  logic [4:0]         src_index,
	input  logic [4:0]         tgt_index,
	input  logic [4:0]         dst_index,
	input  logic [4:0]         shift_amount,
	input  logic signed [15:0] imm_value,
	input  logic [25:0]        jump_target,
	input  logic [31:0]        current_pc,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [31:0]        next_pc,
	output logic               reg_written,
	output logic [4:0]         written_index,
	output logic [31:0]        written_value,
	output logic               write_zero_error,
	output logic               overflow_error
);

	logic              valid_s1;
	mrae_pkg::instr_t  instr_s1;
	logic              valid_s2;
	mrae_pkg::result_t res_s2;

	mrae_pkg::result_t res;
	mrae_pkg::wb_t     wb;
	logic [31:0]       a_data;
	logic [31:0]       b_data;
	logic              accept;
	logic              adv_s1;

	// Advance the input stage when the result register is empty or draining.
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	// Take a new transaction when the input stage is empty or moving on.
	assign req_ready = !valid_s1 || adv_s1;
	assign accept    = req_valid && req_ready;

	// Commit the write only as the instruction retires into the result register.
	assign wb.en  = adv_s1 && res.reg_written;
	assign wb.idx = res.written_index;
	assign wb.val = res.written_value;

	mrae_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_a_idx  (src_index),
		.rd_b_idx  (tgt_index),
		.wb        (wb),
		.rd_a_data (a_data),
		.rd_b_data (b_data)
	);

	mrae_alu u_alu (
		.instr (instr_s1),
		.a     (a_data),
		.b     (b_data),
		.res   (res)
	);

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the decoded fields and the result; hold them while stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1.opcode       <= opcode;
			instr_s1.tgt_index    <= tgt_index;
			instr_s1.dst_index    <= dst_index;
			instr_s1.shift_amount <= shift_amount;
			instr_s1.imm_value    <= imm_value;
			instr_s1.jump_target  <= jump_target;
			instr_s1.current_pc   <= current_pc;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign rsp_valid        = valid_s2;
	assign next_pc          = res_s2.next_pc;
	assign reg_written      = res_s2.reg_written;
	assign written_index    = res_s2.written_index;
	assign written_value    = res_s2.written_value;
	assign write_zero_error = res_s2.write_zero_error;
	assign overflow_error   = res_s2.overflow_error;

endmodule

FILE: rtl/core/mrae_checker.sv
`include "mips_regfile_alu_execute_core_assert.svh"

module mrae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] next_pc,
	input logic        reg_written,
	input logic [4:0]  written_index,
	input logic [31:0] written_value,
	input logic        write_zero_error,
	input logic        overflow_error
);

	`MRAE_ASSERT_NOW(a_zero_err_no_write, clk, arst_n, rsp_valid && write_zero_error, !reg_written, "register zero write reported as done")
	`MRAE_ASSERT_NOW(a_idle_fields_zero, clk, arst_n, rsp_valid && !reg_written, (written_index == 5'd0) && (written_value == 32'd0), "fields not cleared without a write")
	`MRAE_ASSERT_NOW(a_no_reg0_write, clk, arst_n, rsp_valid && reg_written, written_index != 5'd0, "register zero written")
	`MRAE_ASSERT_NOW(a_ovf_has_dest, clk, arst_n, rsp_valid && overflow_error, reg_written || write_zero_error, "overflow on an instruction without destination")
	`MRAE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(next_pc) && $stable(written_value), "stalled response changed")

endmodule

bind mips_regfile_alu_execute_core mrae_checker u_mrae_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp_valid),
	.rsp_ready        (rsp_ready),
	.next_pc          (next_pc),
	.reg_written      (reg_written),
	.written_index    (written_index),
	.written_value    (written_value),
	.write_zero_error (write_zero_error),
	.overflow_error   (overflow_error)
);
